// ===== rtl/nnpo_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the nearest neighbor path order block.
// No dependencies; imported by the top level.
package nnpo_pkg;

  // default store depth
  localparam int NNPO_MAX_PATHS = 64;

  // field widths
  localparam int COORD_W = 30;
  localparam int CFG_W   = 29;
  localparam int IDX_W   = 6;
  localparam int CUR_W   = COORD_W + 1;
  localparam int DIFF_W  = CUR_W + 1;
  localparam int ABS_W   = DIFF_W - 1;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int DIST_W  = SQ_W + 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_Y = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_RD1,
    S_RD2,
    S_WR1,
    S_WR2,
    S_EMIT
  } state_t;

endpackage

// ===== rtl/nnpo_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module nnpo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/nearest_neighbor_path_order.sv =====
`timescale 1ns / 1ps
// Greedy nearest neighbor ordering of path records (top level).
// Loading: one request per cycle, no result until the last-marked record.
// Ordering of n records: round f reads each slot from f to n-1 once into the four-stage
// distance pipeline, then does two reads and two writes for the swap; a round waits
// in S_EMIT while the output is stalled.
// Reset (rst_n low, synchronous) clears control, count and config; the stores are not cleared.
module nearest_neighbor_path_order
  import nnpo_pkg::*;
#(
  parameter int MAX_PATHS = NNPO_MAX_PATHS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // config write port
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  // input requests
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_begin_x,
  input  logic signed [COORD_W-1:0] in_begin_y,
  input  logic signed [COORD_W-1:0] in_finish_x,
  input  logic signed [COORD_W-1:0] in_finish_y,
  input  logic                      in_last_path,
  // result requests
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          out_order_index,
  output logic                      out_last_order
);

  localparam int AW = $clog2(MAX_PATHS);
  localparam int CW = $clog2(MAX_PATHS + 1);
  localparam int BW = 2 * COORD_W;
  localparam int FW = 2 * COORD_W + IDX_W;

  // config registers
  logic signed [CFG_W-1:0] home_x_r, home_y_r, zero_x_r, zero_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_x_r <= '0;
      home_y_r <= '0;
      zero_x_r <= '0;
      zero_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOME_X: home_x_r <= cfg_wdata;
        REG_HOME_Y: home_y_r <= cfg_wdata;
        REG_ZERO_X: zero_x_r <= cfg_wdata;
        REG_ZERO_Y: zero_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // memories: begin point, and finish point with original index
  logic          b_we, f_we;
  logic [AW-1:0] b_waddr, f_waddr, b_raddr, f_raddr;
  logic [BW-1:0] b_wdata, b_rdata;
  logic [FW-1:0] f_wdata, f_rdata;

  nnpo_ram #(.WIDTH(BW), .DEPTH(MAX_PATHS)) u_begin_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  nnpo_ram #(.WIDTH(FW), .DEPTH(MAX_PATHS)) u_finish_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  // sequencer and working registers
  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic [AW-1:0]           first_r, first_nxt;
  logic [AW-1:0]           scan_r, scan_nxt;
  logic [AW-1:0]           best_r, best_nxt;
  logic [DIST_W-1:0]       bestd_r, bestd_nxt;
  logic signed [CUR_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [BW-1:0]           fb_r, fb_nxt;
  logic [FW-1:0]           ff_r, ff_nxt;
  logic [IDX_W-1:0]        bidx_r, bidx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic                    out_last_r, out_last_nxt;

  // distance pipeline
  logic                    p0_v_r, p0_v_nxt, p1_v_r, p2_v_r;
  logic                    p0_first_r, p0_first_nxt, p1_first_r, p2_first_r;
  logic [AW-1:0]           p0_slot_r, p0_slot_nxt, p1_slot_r, p2_slot_r;
  logic [ABS_W-1:0]        p1_dx_r, p1_dy_r;
  logic [SQ_W-1:0]         p2_sqx_r, p2_sqy_r;

  logic signed [COORD_W-1:0] rd_bx, rd_by;
  logic signed [DIFF_W-1:0]  dx_w, dy_w;
  logic [DIFF_W-1:0]         dxa_w, dya_w;
  logic [DIST_W-1:0]         dist_w;
  logic                      full_w, in_acc_w, out_free_w, round_last_w, emit_w;

  assign in_ready   = (state_r == S_LOAD);
  assign in_acc_w   = in_valid && in_ready;
  assign full_w     = (cnt_r == CW'(MAX_PATHS));
  assign out_free_w = !out_valid_r || out_ready;
  assign round_last_w = ((CW'(first_r) + CW'(1)) == n_r);
  assign emit_w     = ((state_r == S_WR2) || (state_r == S_EMIT)) && out_free_w;

  // stage 1: absolute differences against the current point
  assign rd_bx = b_rdata[COORD_W-1:0];
  assign rd_by = b_rdata[BW-1:COORD_W];
  assign dx_w  = DIFF_W'(rd_bx) - DIFF_W'(cur_x_r);
  assign dy_w  = DIFF_W'(rd_by) - DIFF_W'(cur_y_r);
  assign dxa_w = dx_w[DIFF_W-1] ? DIFF_W'(-dx_w) : DIFF_W'(dx_w);
  assign dya_w = dy_w[DIFF_W-1] ? DIFF_W'(-dy_w) : DIFF_W'(dy_w);

  // stage 3: squared distance
  assign dist_w = DIST_W'(p2_sqx_r) + DIST_W'(p2_sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p0_v_r <= p0_v_nxt;
      p1_v_r <= p0_v_r;
      p2_v_r <= p1_v_r;
    end
    p0_first_r <= p0_first_nxt;
    p0_slot_r  <= p0_slot_nxt;
    p1_first_r <= p0_first_r;
    p1_slot_r  <= p0_slot_r;
    p1_dx_r    <= dxa_w[ABS_W-1:0];
    p1_dy_r    <= dya_w[ABS_W-1:0];
    p2_first_r <= p1_first_r;
    p2_slot_r  <= p1_slot_r;
    p2_sqx_r   <= p1_dx_r * p1_dx_r;
    p2_sqy_r   <= p1_dy_r * p1_dy_r;
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r       <= n_nxt;
    first_r   <= first_nxt;
    scan_r    <= scan_nxt;
    best_r    <= best_nxt;
    bestd_r   <= bestd_nxt;
    cur_x_r   <= cur_x_nxt;
    cur_y_r   <= cur_y_nxt;
    fb_r      <= fb_nxt;
    ff_r      <= ff_nxt;
    bidx_r    <= bidx_nxt;
    out_idx_r <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  // next state, memory accesses and datapath updates
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    first_nxt     = first_r;
    scan_nxt      = scan_r;
    best_nxt      = best_r;
    bestd_nxt     = bestd_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    fb_nxt        = fb_r;
    ff_nxt        = ff_r;
    bidx_nxt      = bidx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    p0_v_nxt      = 1'b0;
    p0_first_nxt  = (scan_r == first_r);
    p0_slot_nxt   = scan_r;
    b_we          = 1'b0;
    f_we          = 1'b0;
    b_waddr       = cnt_r[AW-1:0];
    f_waddr       = cnt_r[AW-1:0];
    b_wdata       = {in_begin_y, in_begin_x};
    f_wdata       = {IDX_W'(cnt_r[AW-1:0]), in_finish_y, in_finish_x};
    b_raddr       = scan_r;
    f_raddr       = scan_r;

    // running minimum, first strictly smaller wins
    if (p2_v_r && (p2_first_r || (dist_w < bestd_r))) begin
      best_nxt  = p2_slot_r;
      bestd_nxt = dist_w;
    end

    case (state_r)
      S_LOAD: begin
        if (in_acc_w) begin
          if (!full_w) begin
            b_we    = 1'b1;
            f_we    = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_last_path) begin
            n_nxt     = full_w ? cnt_r : (cnt_r + CW'(1));
            cnt_nxt   = '0;
            first_nxt = '0;
            scan_nxt  = '0;
            cur_x_nxt = CUR_W'(home_x_r) + CUR_W'(zero_x_r);
            cur_y_nxt = CUR_W'(home_y_r) + CUR_W'(zero_y_r);
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one slot read per cycle into the distance pipeline
        p0_v_nxt = 1'b1;
        if ((CW'(scan_r) + CW'(1)) == n_r) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + AW'(1);
        end
      end
      S_DRAIN: begin
        if (!p0_v_r && !p1_v_r && !p2_v_r) begin
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        b_raddr   = first_r;
        f_raddr   = first_r;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        b_raddr   = best_r;
        f_raddr   = best_r;
        fb_nxt    = b_rdata;
        ff_nxt    = f_rdata;
        state_nxt = S_WR1;
      end
      S_WR1: begin
        // winner moves into the current place
        b_we      = 1'b1;
        f_we      = 1'b1;
        b_waddr   = first_r;
        f_waddr   = first_r;
        b_wdata   = b_rdata;
        f_wdata   = f_rdata;
        bidx_nxt  = f_rdata[FW-1:BW];
        cur_x_nxt = CUR_W'($signed(f_rdata[COORD_W-1:0]));
        cur_y_nxt = CUR_W'($signed(f_rdata[BW-1:COORD_W]));
        state_nxt = S_WR2;
      end
      S_WR2: begin
        // displaced record goes to the winner's old place
        b_we      = 1'b1;
        f_we      = 1'b1;
        b_waddr   = best_r;
        f_waddr   = best_r;
        b_wdata   = fb_r;
        f_wdata   = ff_r;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        state_nxt = S_EMIT;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // hand the visited index to the output register and start the next round, or return to loading after the last
    if (emit_w) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = bidx_r;
      out_last_nxt  = round_last_w;
      if (round_last_w) begin
        state_nxt = S_LOAD;
      end else begin
        first_nxt = first_r + AW'(1);
        scan_nxt  = first_r + AW'(1);
        state_nxt = S_SCAN;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_order_index = out_idx_r;
  assign out_last_order  = out_last_r;

endmodule
